[rtl/sgr_pkg.sv]
// Shared constants, request codes and the 5x7 font for the scaled glyph rasterizer.
`default_nettype none

package sgr_pkg;

  // Framebuffer geometry.
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int MAX_SCALE    = 4;
  localparam int PAGE_COUNT   = (FRAME_HEIGHT + 7) / 8;
  localparam int STORE_SIZE   = PAGE_COUNT * FRAME_WIDTH;
  localparam int ADDR_W       = $clog2(STORE_SIZE);
  localparam int COL_W        = $clog2(FRAME_WIDTH);

  // Rows in use on the last page; the rest lie below the bottom edge.
  localparam int LAST_PAGE_ROWS = FRAME_HEIGHT - 8 * (PAGE_COUNT - 1);
  localparam logic [7:0] LAST_PAGE_MASK = 8'((1 << LAST_PAGE_ROWS) - 1);

  // Glyph shape.
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_PITCH = 6;
  localparam int GLYPH_W     = GLYPH_COLS * GLYPH_ROWS;

  // Field widths of the request and result items.
  localparam int REQ_TYPE_W = 2;
  localparam int CODE_W     = 8;
  localparam int X_W        = 7;
  localparam int Y_W        = 6;
  localparam int SCALE_W    = 3;
  localparam int BADDR_W    = 10;
  localparam int CUR_W      = 8;
  localparam int DATA_W     = 8;

  // Internal widths for the column rasterizer.
  localparam int SC_W   = $clog2(MAX_SCALE + 1);
  localparam int VM_W   = GLYPH_ROWS * MAX_SCALE;
  localparam int NRP    = (VM_W + 7 + 7) / 8;
  localparam int RP_W   = $clog2(NRP);
  localparam int SH_W   = NRP * 8;
  localparam int GC_W   = $clog2(GLYPH_COLS);
  localparam int PG_W   = Y_W - 3;
  localparam int PS_W   = ((PG_W > RP_W) ? PG_W : RP_W) + 1;

  // Request codes.
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_DRAW  = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

  typedef logic [GLYPH_ROWS-1:0] glyph_col_t;

  // Font lookup: the leftmost column is in the top bits. Lowercase folds to
  // uppercase, and anything missing from the font draws a question mark.
  function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] c;
    logic [GLYPH_W-1:0] g;
    c = code;
    if (c inside {["a":"z"]}) begin
      c = c - 8'("a" - "A");
    end
    case (c)
      "A": g = {7'd126, 7'd9,   7'd9,   7'd9,   7'd126};
      "B": g = {7'd127, 7'd73,  7'd73,  7'd73,  7'd54};
      "C": g = {7'd62,  7'd65,  7'd65,  7'd65,  7'd34};
      "D": g = {7'd127, 7'd65,  7'd65,  7'd34,  7'd28};
      "E": g = {7'd127, 7'd73,  7'd73,  7'd73,  7'd65};
      "F": g = {7'd127, 7'd9,   7'd9,   7'd9,   7'd1};
      "G": g = {7'd62,  7'd65,  7'd73,  7'd73,  7'd122};
      "H": g = {7'd127, 7'd8,   7'd8,   7'd8,   7'd127};
      "I": g = {7'd65,  7'd65,  7'd127, 7'd65,  7'd65};
      "J": g = {7'd32,  7'd64,  7'd65,  7'd63,  7'd1};
      "K": g = {7'd127, 7'd8,   7'd20,  7'd34,  7'd65};
      "L": g = {7'd127, 7'd64,  7'd64,  7'd64,  7'd64};
      "M": g = {7'd127, 7'd2,   7'd12,  7'd2,   7'd127};
      "N": g = {7'd127, 7'd4,   7'd8,   7'd16,  7'd127};
      "O": g = {7'd62,  7'd65,  7'd65,  7'd65,  7'd62};
      "P": g = {7'd127, 7'd9,   7'd9,   7'd9,   7'd6};
      "Q": g = {7'd62,  7'd65,  7'd81,  7'd33,  7'd94};
      "R": g = {7'd127, 7'd9,   7'd25,  7'd41,  7'd70};
      "S": g = {7'd38,  7'd73,  7'd73,  7'd73,  7'd50};
      "T": g = {7'd1,   7'd1,   7'd127, 7'd1,   7'd1};
      "U": g = {7'd63,  7'd64,  7'd64,  7'd64,  7'd63};
      "V": g = {7'd31,  7'd32,  7'd64,  7'd32,  7'd31};
      "W": g = {7'd63,  7'd64,  7'd56,  7'd64,  7'd63};
      "X": g = {7'd99,  7'd20,  7'd8,   7'd20,  7'd99};
      "Y": g = {7'd3,   7'd4,   7'd120, 7'd4,   7'd3};
      "Z": g = {7'd97,  7'd81,  7'd73,  7'd69,  7'd67};
      "0": g = {7'd62,  7'd81,  7'd73,  7'd69,  7'd62};
      "1": g = {7'd0,   7'd66,  7'd127, 7'd64,  7'd0};
      "2": g = {7'd98,  7'd81,  7'd73,  7'd73,  7'd70};
      "3": g = {7'd34,  7'd65,  7'd73,  7'd73,  7'd54};
      "4": g = {7'd24,  7'd20,  7'd18,  7'd127, 7'd16};
      "5": g = {7'd39,  7'd69,  7'd69,  7'd69,  7'd57};
      "6": g = {7'd60,  7'd74,  7'd73,  7'd73,  7'd48};
      "7": g = {7'd1,   7'd113, 7'd9,   7'd5,   7'd3};
      "8": g = {7'd54,  7'd73,  7'd73,  7'd73,  7'd54};
      "9": g = {7'd6,   7'd73,  7'd73,  7'd41,  7'd30};
      " ": g = {7'd0,   7'd0,   7'd0,   7'd0,   7'd0};
      "!": g = {7'd0,   7'd0,   7'd95,  7'd0,   7'd0};
      "+": g = {7'd8,   7'd8,   7'd62,  7'd8,   7'd8};
      "-": g = {7'd8,   7'd8,   7'd8,   7'd8,   7'd8};
      ":": g = {7'd0,   7'd0,   7'd36,  7'd0,   7'd0};
      "/": g = {7'd32,  7'd16,  7'd8,   7'd4,   7'd2};
      ".": g = {7'd0,   7'd96,  7'd96,  7'd0,   7'd0};
      "=": g = {7'd20,  7'd20,  7'd20,  7'd20,  7'd20};
      "_": g = {7'd64,  7'd64,  7'd64,  7'd64,  7'd64};
      default: g = {7'd2, 7'd1, 7'd81, 7'd9, 7'd6};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/sgr_req_if.sv]
// Request channel: valid/ready handshake with the request item fields.
`default_nettype none

interface sgr_req_if import sgr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [CODE_W-1:0]     char_code;
  logic                  first_char;
  logic [X_W-1:0]        start_x;
  logic [Y_W-1:0]        start_y;
  logic [SCALE_W-1:0]    scale;
  logic [BADDR_W-1:0]    byte_addr;

  modport source (
    output valid, req_type, char_code, first_char, start_x, start_y, scale, byte_addr,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, first_char, start_x, start_y, scale, byte_addr,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sgr_res_if.sv]
// Result channel: valid/ready handshake with the result item fields.
`default_nettype none

interface sgr_res_if import sgr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              placed;
  logic [CUR_W-1:0]  cursor_after;

  modport source (
    output valid, read_data, placed, cursor_after,
    input  ready
  );
  modport sink (
    input  valid, read_data, placed, cursor_after,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sgr_frame_ram.sv]
// Simple dual-port framebuffer RAM: one write port, one registered read port.
`default_nettype none

module sgr_frame_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/sgr_col_mask.sv]
// Builds the OR mask for one page byte of one scaled glyph column.
`default_nettype none

module sgr_col_mask import sgr_pkg::*; (
  input  wire logic [GLYPH_ROWS-1:0] glyph_col,
  input  wire logic [SC_W-1:0]       sc,
  input  wire logic [2:0]            offset,
  input  wire logic [RP_W-1:0]       rp,
  output logic      [7:0]            mask
);

  logic [VM_W-1:0] vmask;
  logic [SH_W-1:0] shifted;

  // Stretch each glyph row into sc consecutive pixel rows.
  always_comb begin
    vmask = '0;
    for (int k = 0; k < VM_W; k++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        if (glyph_col[r] && k >= r * int'(sc) && k < (r + 1) * int'(sc)) begin
          vmask[k] = 1'b1;
        end
      end
    end
  end

  // Align to the row within the first page, then pick the page byte.
  assign shifted = SH_W'(vmask) << offset;
  assign mask    = shifted[rp * 8 +: 8];

endmodule

`default_nettype wire

[rtl/scaled_glyph_rasterizer.sv]
// Top level of the scaled glyph rasterizer: request sequencer around the framebuffer RAM.
//
//   Channel | Dir | Fields
//   --------+-----+-------------------------------------------------------------
//   req     | in  | req_type, char_code, first_char, start_x, start_y, scale,
//           |     | byte_addr
//   res     | out | read_data, placed, cursor_after
//
// One item is worked on at a time. A draw visits each of the 5*scale pixel
// columns on each page (1 to 5) that the scaled glyph spans: the RAM read port
// handles one page byte per cycle, with the OR write trailing in the next cycle.
// A clear writes one RAM word per cycle. After reset the same clearing pass
// covers all 1024 words before the first item is taken. A finished result
// waits in the output register; the next item is taken while it waits.
`default_nettype none

module scaled_glyph_rasterizer import sgr_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  sgr_req_if.sink    req,
  sgr_res_if.source  res
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_DRAW  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam int CS_W = CUR_W + 1;

  state_t state;

  // Control state.
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_req;
  logic [CUR_W-1:0]  cursor_col;
  logic              clipped;
  logic              res_valid;
  logic              pend_v;

  // Per-item working registers.
  glyph_col_t        glyph_cols [GLYPH_COLS];
  logic [SC_W-1:0]   sc;
  logic [PG_W-1:0]   pg0;
  logic [2:0]        offset;
  logic [RP_W-1:0]   end_rp;
  logic [GC_W-1:0]   gc;
  logic [SC_W-1:0]   dx;
  logic [RP_W-1:0]   rp;
  logic [COL_W-1:0]  px;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_mask;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_ok;
  logic              is_read;
  logic              placed_r;

  // Output register.
  logic [DATA_W-1:0] out_read_data;
  logic              out_placed;
  logic [CUR_W-1:0]  out_cursor;

  // Accept-time decode.
  logic [SC_W-1:0]          sc_in;
  logic [CUR_W-1:0]         cur_eff;
  logic                     clip_eff;
  logic [CS_W-1:0]          fit_sum;
  logic [CS_W-1:0]          adv_sum;
  logic                     fits;
  logic [GLYPH_W-1:0]       glyph_bits;

  // Draw datapath.
  logic [PS_W-1:0]   page_sum;
  logic              last_page;
  logic              last_rp;
  logic [ADDR_W-1:0] draw_addr;
  logic [7:0]        col_byte;
  logic [7:0]        draw_byte;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign req.ready        = (state == ST_IDLE);
  assign res.valid        = res_valid;
  assign res.read_data    = out_read_data;
  assign res.placed       = out_placed;
  assign res.cursor_after = out_cursor;

  // Scale clamp, string start and the right-edge fit check.
  always_comb begin
    if (req.scale == '0) begin
      sc_in = SC_W'(1);
    end else if (int'(req.scale) > MAX_SCALE) begin
      sc_in = SC_W'(MAX_SCALE);
    end else begin
      sc_in = SC_W'(req.scale);
    end
    cur_eff    = req.first_char ? CUR_W'(req.start_x) : cursor_col;
    clip_eff   = req.first_char ? 1'b0 : clipped;
    fit_sum    = CS_W'(cur_eff) + CS_W'(GLYPH_COLS * int'(sc_in));
    adv_sum    = CS_W'(cur_eff) + CS_W'(GLYPH_PITCH * int'(sc_in));
    fits       = fit_sum <= CS_W'(FRAME_WIDTH);
    glyph_bits = glyph_lookup(req.char_code);
  end

  // Address and mask of the page byte visited this cycle.
  assign page_sum  = PS_W'(pg0) + PS_W'(rp);
  assign last_page = (page_sum == PS_W'(PAGE_COUNT - 1));
  assign last_rp   = (rp == end_rp) || last_page;
  assign draw_addr = ADDR_W'(page_sum) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(px);
  assign draw_byte = last_page ? (col_byte & LAST_PAGE_MASK) : col_byte;

  sgr_col_mask u_col_mask (
    .glyph_col (glyph_cols[gc]),
    .sc        (sc),
    .offset    (offset),
    .rp        (rp),
    .mask      (col_byte)
  );

  // RAM port steering: clearing sweep, trailing OR write, and reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata | pend_mask;
    ram_re    = 1'b0;
    ram_raddr = draw_addr;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if ((state == ST_DRAW || state == ST_DRAIN) && pend_v) begin
      ram_we = 1'b1;
    end
    if (state == ST_DRAW) begin
      ram_re = 1'b1;
    end else if (state == ST_READ) begin
      ram_re    = 1'b1;
      ram_raddr = rd_addr;
    end
  end

  sgr_frame_ram #(
    .DEPTH (STORE_SIZE),
    .WIDTH (DATA_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_req   <= 1'b0;
      cursor_col <= '0;
      clipped   <= 1'b0;
      res_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            is_read  <= 1'b0;
            placed_r <= 1'b0;
            case (req.req_type)
              REQ_CLEAR: begin
                clr_addr <= '0;
                clr_req  <= 1'b1;
                state    <= ST_CLEAR;
              end
              REQ_DRAW: begin
                state <= ST_DONE;
                if (req.first_char) begin
                  cursor_col <= CUR_W'(req.start_x);
                  clipped    <= 1'b0;
                end
                if (!clip_eff) begin
                  if (!fits) begin
                    clipped <= 1'b1;
                  end else begin
                    placed_r   <= 1'b1;
                    cursor_col <= adv_sum[CUR_W] ? '1 : adv_sum[CUR_W-1:0];
                    for (int c = 0; c < GLYPH_COLS; c++) begin
                      glyph_cols[c] <= glyph_bits[(GLYPH_COLS-1-c)*GLYPH_ROWS +: GLYPH_ROWS];
                    end
                    sc     <= sc_in;
                    pg0    <= req.start_y[Y_W-1:3];
                    offset <= req.start_y[2:0];
                    end_rp <= RP_W'((int'(req.start_y[2:0]) + GLYPH_ROWS * int'(sc_in) - 1)
                                    >> 3);
                    gc     <= '0;
                    dx     <= '0;
                    rp     <= '0;
                    px     <= COL_W'(cur_eff);
                    if (int'(req.start_y[Y_W-1:3]) < PAGE_COUNT) begin
                      state <= ST_DRAW;
                    end
                  end
                end
              end
              REQ_READ: begin
                is_read <= 1'b1;
                rd_addr <= ADDR_W'(req.byte_addr);
                rd_ok   <= int'(req.byte_addr) < STORE_SIZE;
                state   <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
            clr_req <= 1'b0;
            state   <= clr_req ? ST_DONE : ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DRAW: begin
          // Queue the OR write for the byte being read; walk page, dx, column.
          pend_v    <= 1'b1;
          pend_addr <= draw_addr;
          pend_mask <= draw_byte;
          if (last_rp) begin
            rp <= '0;
            px <= px + 1'b1;
            if (dx == sc - 1'b1) begin
              dx <= '0;
              if (gc == GC_W'(GLYPH_COLS - 1)) begin
                state <= ST_DRAIN;
              end else begin
                gc <= gc + 1'b1;
              end
            end else begin
              dx <= dx + 1'b1;
            end
          end else begin
            rp <= rp + 1'b1;
          end
        end
        ST_DRAIN: begin
          pend_v <= 1'b0;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid     <= 1'b1;
            out_read_data <= (is_read && rd_ok) ? ram_rdata : '0;
            out_placed    <= placed_r;
            out_cursor    <= cursor_col;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The trailing write never targets the byte being read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW && pend_v) |-> (draw_addr != pend_addr))
    else $error("draw read and pending write hit the same byte");

  // Draw counters stay inside the glyph and the page span.
  a_draw_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW) |-> (gc < GC_W'(GLYPH_COLS) && dx < sc && rp <= end_rp))
    else $error("draw counters out of range");

  // The clearing sweep runs to the last word before leaving.
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_addr != ADDR_W'(STORE_SIZE - 1)) |=> (state == ST_CLEAR))
    else $error("clearing sweep left early");

  // A result is loaded only from the done state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done state");

  // A placed character always leaves the cursor at least one pitch in.
  a_placed_cursor: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_placed) |-> (out_cursor >= CUR_W'(GLYPH_PITCH)))
    else $error("placed character with cursor below one pitch");

endmodule

`default_nettype wire
